// File: hw/rtl/lcmq_pkg.sv
// Types and constants of the line container maximum query block.
// Used by lcmq_div and line_container_max_query_top.
`default_nettype none
package lcmq_pkg;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic signed [63:0] INF_BREAK     = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] NEG_INF_BREAK = 64'shC000_0000_0000_0000;

   localparam int ENTRY_W = 136;

   typedef struct packed {
      logic               action;
      logic signed [31:0] slope;
      logic signed [39:0] intercept;
      logic signed [31:0] query_x;
   } lcmq_req_type;

   typedef struct packed {
      logic signed [63:0] best_value;
      logic               table_empty;
      logic               table_full;
   } lcmq_rsp_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [39:0] intercept;
      logic signed [63:0] brk;
   } lcmq_entry_type;

   typedef struct packed {
      logic               start;
      logic signed [40:0] num;
      logic signed [32:0] den;
   } lcmq_div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] quot;
   } lcmq_div_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/lcmq_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/lcmq_div.sv
// Iterative floored divider, one quotient bit per cycle.
// Depends on lcmq_pkg.
`default_nettype none
module lcmq_div
   import lcmq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lcmq_div_req_type div_req,
   output lcmq_div_rsp_type      div_rsp
);
   logic        run_ff, run_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [40:0] q_ff, q_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dmag_ff, dmag_in;
   logic signed [63:0] quot_ff, quot_in;
   logic [33:0] rem_sh;
   logic [33:0] trial;
   logic [63:0] q64;

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff[32:0], q_ff[40]};
      trial   = rem_sh - {1'b0, dmag_ff};
      q64     = {23'd0, q_ff};
      if (div_req.start) begin
         run_in  = 1'b1;
         step_in = '0;
         neg_in  = div_req.num[40] ^ div_req.den[32];
         q_in    = div_req.num[40] ? 41'(-div_req.num) : div_req.num;
         dmag_in = div_req.den[32] ? 33'(-div_req.den) : div_req.den;
         rem_in  = '0;
      end else if (run_ff) begin
         if (!trial[33]) begin
            rem_in = trial;
            q_in   = {q_ff[39:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[39:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd40) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            quot_in = $signed(-q64 - {63'd0, (rem_ff != '0)});
         end else begin
            quot_in = $signed(q64);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
endmodule
`default_nettype wire

// File: hw/rtl/line_container_max_query_top.sv
// Line container maximum query: upper envelope of lines, one request at a time.
// Depends on lcmq_pkg, lcmq_ram and lcmq_div.
//
// A request is taken when start is high and busy is low; its single result
// appears on rsp_payload for one cycle with rsp_strobe high and cannot be
// held off. A query does a binary search over the break points, one RAM
// read per probe, then one multiply. An add scans the stored lines of
// smaller or equal slope (linear scan), moves lines up, then recomputes
// break points using the shared bit-serial divider and moves lines down
// for each removed line; all limited by the single RAM port pair.
// A full-table add or an empty-table query goes straight from idle to the
// done state.
`default_nettype none
module line_container_max_query_top
   import lcmq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire lcmq_req_type req_payload,
   output logic              rsp_strobe,
   output lcmq_rsp_type      rsp_payload
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [4:0] S_IDLE = 5'd0,  S_SC_A = 5'd1,  S_SC_B = 5'd2,  S_UP0  = 5'd3,
                          S_UP_A = 5'd4,  S_UP_B = 5'd5,  S_INS  = 5'd6,  S_P1   = 5'd7,
                          S_P1R  = 5'd8,  S_P2   = 5'd9,  S_P2R  = 5'd10, S_P2C  = 5'd11,
                          S_P3   = 5'd12, S_P3B  = 5'd13, S_P3C  = 5'd14, S_P3D  = 5'd15,
                          S_CR_A = 5'd16, S_CR_B = 5'd17, S_CR_C = 5'd18, S_CR_D = 5'd19,
                          S_CR_W = 5'd20, S_RM_A = 5'd21, S_RM_B = 5'd22, S_Q_BS = 5'd23,
                          S_Q_BC = 5'd24, S_Q_RD = 5'd25, S_Q_MU = 5'd26, S_Q_AD = 5'd27,
                          S_DONE = 5'd28;

   logic [4:0]     state_ff, state_in;
   logic [4:0]     ret_ff, ret_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           strobe_ff, strobe_in;
   lcmq_req_type   req_ff, req_in;
   lcmq_rsp_type   out_ff, out_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  x_ff, x_in;
   logic [CW-1:0]  y_ff, y_in;
   logic [CW-1:0]  a_idx_ff, a_idx_in;
   logic [CW-1:0]  b_idx_ff, b_idx_in;
   logic [CW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  hi_ff, hi_in;
   logic [CW-1:0]  mid_ff, mid_in;
   lcmq_entry_type a_ff, a_in;
   logic signed [63:0] b_brk_ff, b_brk_in;
   logic           b_ok_ff, b_ok_in;
   logic signed [63:0] brk_ff, brk_in;
   logic           hit_ff, hit_in;
   logic signed [63:0] prod_ff, prod_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [AW-1:0]  ram_raddr;
   lcmq_entry_type ram_wdata;
   lcmq_entry_type ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;
   lcmq_div_req_type   div_req;
   lcmq_div_rsp_type   div_rsp;
   logic signed [63:0] qx64;
   logic [CW-1:0]      mid_c;

   lcmq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );
   assign ram_rdata = ram_rbits;

   lcmq_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign qx64  = {{32{req_ff.query_x[31]}}, req_ff.query_x};
   assign mid_c = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      req_in    = req_ff;
      out_in    = out_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      a_idx_in  = a_idx_ff;
      b_idx_in  = b_idx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      a_in      = a_ff;
      b_brk_in  = b_brk_ff;
      b_ok_in   = b_ok_ff;
      brk_in    = brk_ff;
      hit_in    = hit_ff;
      prod_in   = prod_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      div_req.start = 1'b0;
      div_req.num   = 41'($signed(ram_rdata.intercept)) - 41'($signed(a_ff.intercept));
      div_req.den   = 33'($signed(a_ff.slope)) - 33'($signed(ram_rdata.slope));

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_payload;
               out_in = '0;
               if (req_payload.action == ACT_ADD) begin
                  pos_in = '0;
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     out_in.table_full = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SC_A;
                  end
               end else if (cnt_ff == '0) begin
                  out_in.table_empty = 1'b1;
                  state_in = S_DONE;
               end else begin
                  lo_in = '0;
                  hi_in = cnt_ff - CW'(1);
                  state_in = S_Q_BS;
               end
            end
         end
         S_SC_A: begin
            ram_raddr = pos_ff[AW-1:0];
            state_in  = (pos_ff < cnt_ff) ? S_SC_B : S_UP0;
         end
         S_SC_B: begin
            if (ram_rdata.slope <= req_ff.slope) begin
               pos_in   = pos_ff + CW'(1);
               state_in = S_SC_A;
            end else begin
               state_in = S_UP0;
            end
         end
         S_UP0: begin
            idx_in   = cnt_ff - CW'(1);
            state_in = (cnt_ff == pos_ff) ? S_INS : S_UP_A;
         end
         S_UP_A: begin
            ram_raddr = idx_ff[AW-1:0];
            state_in  = S_UP_B;
         end
         S_UP_B: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_ff + CW'(1));
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - CW'(1);
            state_in  = (idx_ff == pos_ff) ? S_INS : S_UP_A;
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = '{slope: req_ff.slope, intercept: req_ff.intercept, brk: '0};
            cnt_in    = cnt_ff + CW'(1);
            y_in      = pos_ff;
            state_in  = S_P1;
         end
         S_P1: begin
            a_idx_in = y_ff;
            b_idx_in = y_ff + CW'(1);
            ret_in   = S_P1R;
            state_in = S_CR_A;
         end
         S_P1R: begin
            if (hit_ff) begin
               idx_in   = y_ff + CW'(1);
               ret_in   = S_P1;
               state_in = S_RM_A;
            end else begin
               state_in = S_P2;
            end
         end
         S_P2: begin
            x_in = y_ff;
            if (y_ff == '0) begin
               state_in = S_P3;
            end else begin
               x_in     = y_ff - CW'(1);
               a_idx_in = y_ff - CW'(1);
               b_idx_in = y_ff;
               ret_in   = S_P2R;
               state_in = S_CR_A;
            end
         end
         S_P2R: begin
            if (hit_ff) begin
               idx_in   = y_ff;
               ret_in   = S_P2C;
               state_in = S_RM_A;
            end else begin
               state_in = S_P3;
            end
         end
         S_P2C: begin
            a_idx_in = x_ff;
            b_idx_in = x_ff + CW'(1);
            ret_in   = S_P3;
            state_in = S_CR_A;
         end
         S_P3: begin
            y_in = x_ff;
            if (x_ff == '0) begin
               state_in = S_DONE;
            end else begin
               x_in      = x_ff - CW'(1);
               ram_raddr = AW'(x_ff - CW'(1));
               state_in  = S_P3B;
            end
         end
         S_P3B: begin
            a_in      = ram_rdata;
            ram_raddr = y_ff[AW-1:0];
            state_in  = S_P3C;
         end
         S_P3C: begin
            if (a_ff.brk >= ram_rdata.brk) begin
               idx_in   = y_ff;
               ret_in   = S_P3D;
               state_in = S_RM_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_P3D: begin
            a_idx_in = x_ff;
            b_idx_in = x_ff + CW'(1);
            ret_in   = S_P3;
            state_in = S_CR_A;
         end
         S_CR_A: begin
            ram_raddr = a_idx_ff[AW-1:0];
            state_in  = S_CR_B;
         end
         S_CR_B: begin
            a_in = ram_rdata;
            if (b_idx_ff >= cnt_ff) begin
               b_ok_in  = 1'b0;
               brk_in   = INF_BREAK;
               state_in = S_CR_W;
            end else begin
               b_ok_in   = 1'b1;
               ram_raddr = b_idx_ff[AW-1:0];
               state_in  = S_CR_C;
            end
         end
         S_CR_C: begin
            b_brk_in = ram_rdata.brk;
            if (a_ff.slope == ram_rdata.slope) begin
               brk_in   = (a_ff.intercept > ram_rdata.intercept) ? INF_BREAK : NEG_INF_BREAK;
               state_in = S_CR_W;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_CR_D;
            end
         end
         S_CR_D: begin
            if (div_rsp.done) begin
               brk_in   = div_rsp.quot;
               state_in = S_CR_W;
            end
         end
         S_CR_W: begin
            ram_we    = 1'b1;
            ram_waddr = a_idx_ff[AW-1:0];
            ram_wdata = '{slope: a_ff.slope, intercept: a_ff.intercept, brk: brk_ff};
            hit_in    = b_ok_ff && (brk_ff >= b_brk_ff);
            state_in  = ret_ff;
         end
         S_RM_A: begin
            ram_raddr = AW'(idx_ff + CW'(1));
            if (idx_ff + CW'(1) >= cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ret_ff;
            end else begin
               state_in = S_RM_B;
            end
         end
         S_RM_B: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_ff + CW'(1);
            state_in  = S_RM_A;
         end
         S_Q_BS: begin
            mid_in    = mid_c;
            ram_raddr = mid_c[AW-1:0];
            state_in  = (lo_ff < hi_ff) ? S_Q_BC : S_Q_RD;
         end
         S_Q_BC: begin
            if (ram_rdata.brk >= qx64) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + CW'(1);
            end
            state_in = S_Q_BS;
         end
         S_Q_RD: begin
            ram_raddr = lo_ff[AW-1:0];
            state_in  = S_Q_MU;
         end
         S_Q_MU: begin
            a_in     = ram_rdata;
            prod_in  = ram_rdata.slope * req_ff.query_x;
            state_in = S_Q_AD;
         end
         S_Q_AD: begin
            out_in.best_value = prod_ff + 64'(a_ff.intercept);
            state_in = S_DONE;
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      req_ff   <= req_in;
      out_ff   <= out_in;
      pos_ff   <= pos_in;
      idx_ff   <= idx_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      a_idx_ff <= a_idx_in;
      b_idx_ff <= b_idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      a_ff     <= a_in;
      b_brk_ff <= b_brk_in;
      b_ok_ff  <= b_ok_in;
      brk_ff   <= brk_in;
      hit_ff   <= hit_in;
      prod_ff  <= prod_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = out_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("line count beyond capacity");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without going busy");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_payload.table_empty && rsp_payload.table_full))
      else $error("empty and full flagged together");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(state_ff == S_DONE))
      else $error("result strobe outside completion");
endmodule
`default_nettype wire
